// ===== rtl/tabular_q_learning_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Q-learning engine
// Concurrent checks used in the top level.
// ----------------------------------------------------------------------------
`ifndef TABULAR_Q_LEARNING_ENGINE_ASSERT_SVH
`define TABULAR_Q_LEARNING_ENGINE_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define TQLE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define TQLE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tqle_pkg.sv =====
// ----------------------------------------------------------------------------
// tqle_pkg
// Shared widths, codes and helpers of the Q-learning engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tqle_pkg;

   localparam int VALUE_W    = 32;
   localparam int GAIN_W     = 17;
   localparam int STATES_W   = 9;
   localparam int COUNT_W    = 4;
   localparam int STATE_W    = 8;
   localparam int ACTION_W   = 3;
   localparam int DRAW_W     = 16;
   localparam int FUNC_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int SAT_W      = 40;
   localparam int MOD_BITS   = 4;
   localparam int MOD_STEPS  = DRAW_W / MOD_BITS;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SELECT = 2'd0,
      FUNC_UPDATE = 2'd1,
      FUNC_READ   = 2'd2
   } func_type;

   localparam logic [CSR_IDX_W-1:0] CSR_STATES  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIONS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EPS     = 3'd4;

   localparam logic [STATES_W-1:0] RST_STATES  = 9'd256;
   localparam logic [COUNT_W-1:0]  RST_ACTIONS = 4'd8;
   localparam logic [GAIN_W-1:0]   RST_ALPHA   = 17'd6554;
   localparam logic [GAIN_W-1:0]   RST_GAMMA   = 17'd62259;
   localparam logic [GAIN_W-1:0]   RST_EPS     = 17'd6554;

   // clamp a wide two's complement value to 32 bits
   function automatic logic [VALUE_W-1:0] sat_value(input logic [SAT_W-1:0] x);
      logic [SAT_W-VALUE_W:0] top;
      top = x[SAT_W-1:VALUE_W-1];
      if (top == '0 || top == '1) begin
         return x[VALUE_W-1:0];
      end else if (x[SAT_W-1]) begin
         return {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(VALUE_W-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tqle_ram.sv =====
// ----------------------------------------------------------------------------
// tqle_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tqle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tabular_q_learning_engine.sv =====
// ----------------------------------------------------------------------------
// tabular_q_learning_engine
// Q-value table with epsilon-greedy select, TD update and entry read.
//
//   Port group  Dir  Handshake          Word
//   req_*       in   req_valid/stall    func, indexes, reward, draws
//   rsp_*       out  rsp_valid/stall    chosen_action, entry_value
//   csr_*       in   csr_wr_en          csr_index, csr_wr_data
//
// N = active actions. A greedy select and a bootstrapping update read the
// N row entries on the one table read port; an update then does two
// multiplies. An update that bootstraps nothing skips the row reads.
// After reset a clearing pass writes MAX_STATES*MAX_ACTIONS zeros, one a
// cycle; req_stall stays high meanwhile. csr writes are taken at any time.
// A word waiting in the rsp register does not block the next req word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tabular_q_learning_engine_assert.svh"

module tabular_q_learning_engine
   import tqle_pkg::*;
#(
   parameter int MAX_STATES  = 256,
   parameter int MAX_ACTIONS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [FUNC_W-1:0]            req_func,
   input  logic [STATE_W-1:0]           req_state_index,
   input  logic [ACTION_W-1:0]          req_action_index,
   input  logic signed [VALUE_W-1:0]    req_reward,
   input  logic [STATE_W-1:0]           req_next_state_index,
   input  logic                         req_episode_done,
   input  logic [DRAW_W-1:0]            req_explore_draw,
   input  logic [DRAW_W-1:0]            req_explore_pick,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ACTION_W-1:0]          rsp_chosen_action,
   output logic signed [VALUE_W-1:0]    rsp_entry_value,
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wr_data
);

   localparam int DEPTH  = MAX_STATES * MAX_ACTIONS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int LIN_W  = ADDR_W + STATE_W + COUNT_W;
   localparam int MCNT_W = $clog2(MOD_STEPS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [MCNT_W-1:0] MOD_LAST  = MCNT_W'(MOD_STEPS - 1);

   typedef enum logic [11:0] {
      ST_CLEAR  = 12'b0000_0000_0001,
      ST_IDLE   = 12'b0000_0000_0010,
      ST_MOD    = 12'b0000_0000_0100,
      ST_QREAD  = 12'b0000_0000_1000,
      ST_QDATA  = 12'b0000_0001_0000,
      ST_SCAN   = 12'b0000_0010_0000,
      ST_SLAST  = 12'b0000_0100_0000,
      ST_MUL1   = 12'b0000_1000_0000,
      ST_TGT    = 12'b0001_0000_0000,
      ST_MUL2   = 12'b0010_0000_0000,
      ST_WRITE  = 12'b0100_0000_0000,
      ST_RESULT = 12'b1000_0000_0000
   } fsm_type;

   function automatic logic [ADDR_W-1:0] entry_addr(input logic [STATE_W-1:0] row,
                                                    input logic [COUNT_W-1:0] col);
      logic [LIN_W-1:0] lin;
      lin = LIN_W'(row) * LIN_W'(MAX_ACTIONS) + LIN_W'(col);
      return lin[ADDR_W-1:0];
   endfunction

   // control state
   fsm_type             fsm_ff, fsm_in;
   logic [ADDR_W-1:0]   clear_addr_ff, clear_addr_in;
   logic [COUNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic                pend_ff, pend_in;
   logic [MCNT_W-1:0]   mod_cnt_ff, mod_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                op_update_ff, op_update_in;
   logic                op_boot_ff, op_boot_in;

   // configuration
   logic [STATES_W-1:0] csr_states_ff, csr_states_in;
   logic [COUNT_W-1:0]  csr_actions_ff, csr_actions_in;
   logic [GAIN_W-1:0]   csr_alpha_ff, csr_alpha_in;
   logic [GAIN_W-1:0]   csr_gamma_ff, csr_gamma_in;
   logic [GAIN_W-1:0]   csr_eps_ff, csr_eps_in;

   // datapath
   logic [STATE_W-1:0]        op_state_ff, op_state_in;
   logic [ACTION_W-1:0]       op_action_ff, op_action_in;
   logic signed [VALUE_W-1:0] op_reward_ff, op_reward_in;
   logic [STATE_W-1:0]        scan_row_ff, scan_row_in;
   logic [DRAW_W-1:0]         mod_pick_ff, mod_pick_in;
   logic [COUNT_W-1:0]        mod_rem_ff, mod_rem_in;
   logic [COUNT_W-1:0]        pend_idx_ff, pend_idx_in;
   logic signed [VALUE_W-1:0] best_val_ff, best_val_in;
   logic [COUNT_W-1:0]        best_idx_ff, best_idx_in;
   logic signed [VALUE_W-1:0] q_ff, q_in;
   logic signed [VALUE_W-1:0] max_ff, max_in;
   logic signed [49:0]        prod1_ff, prod1_in;
   logic signed [VALUE_W-1:0] target_ff, target_in;
   logic signed [50:0]        prod2_ff, prod2_in;
   logic [ACTION_W-1:0]       res_action_ff, res_action_in;
   logic [VALUE_W-1:0]        res_value_ff, res_value_in;
   logic [ACTION_W-1:0]       rsp_action_ff, rsp_action_in;
   logic [VALUE_W-1:0]        rsp_value_ff, rsp_value_in;

   // combinational
   logic [STATES_W-1:0]       n_states;
   logic [COUNT_W-1:0]        n_actions;
   logic                      req_accept;
   logic                      s_ok, a_ok, ns_ok, explore;
   fsm_type                   accept_next;
   logic [COUNT_W-1:0]        mod_rem_step;
   logic                      take;
   logic signed [34:0]        tgt_sum;
   logic signed [32:0]        diff;
   logic signed [35:0]        upd_sum;
   logic [VALUE_W-1:0]        new_value;
   logic                      rsp_load;
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [VALUE_W-1:0]        mem_wdata;
   logic [ADDR_W-1:0]         mem_raddr;
   logic [VALUE_W-1:0]        rd_data;

   tqle_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (rd_data)
   );

   // effective table limits
   always_comb begin
      n_states = (32'(csr_states_ff) < MAX_STATES) ? csr_states_ff : STATES_W'(MAX_STATES);
      if (csr_actions_ff == '0) begin
         n_actions = COUNT_W'(1);
      end else if (32'(csr_actions_ff) < MAX_ACTIONS) begin
         n_actions = csr_actions_ff;
      end else begin
         n_actions = COUNT_W'(MAX_ACTIONS);
      end
   end

   assign req_stall  = (fsm_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign s_ok    = {1'b0, req_state_index} < n_states;
   assign a_ok    = {1'b0, req_action_index} < n_actions;
   assign ns_ok   = {1'b0, req_next_state_index} < n_states;
   assign explore = {1'b0, req_explore_draw} < csr_eps_ff;

   always_comb begin
      unique case (req_func)
         FUNC_SELECT: begin
            if (explore) begin
               accept_next = ST_MOD;
            end else if (s_ok) begin
               accept_next = ST_SCAN;
            end else begin
               accept_next = ST_RESULT;
            end
         end
         FUNC_UPDATE: accept_next = (s_ok && a_ok) ? ST_QREAD : ST_IDLE;
         FUNC_READ:   accept_next = (s_ok && a_ok) ? ST_QREAD : ST_RESULT;
         default:     accept_next = ST_IDLE;
      endcase
   end

   // pick mod action count, MOD_BITS bits of the pick per cycle
   always_comb begin
      logic [COUNT_W:0]   trial;
      logic [COUNT_W-1:0] acc;
      acc   = mod_rem_ff;
      trial = '0;
      for (int i = 0; i < MOD_BITS; i++) begin
         trial = {acc, mod_pick_ff[DRAW_W-1-i]};
         if (trial >= {1'b0, n_actions}) begin
            trial = trial - {1'b0, n_actions};
         end
         acc = trial[COUNT_W-1:0];
      end
      mod_rem_step = acc;
   end

   // running maximum, first index wins on ties
   always_comb begin
      take        = (pend_idx_ff == '0) || ($signed(rd_data) > best_val_ff);
      best_val_in = best_val_ff;
      best_idx_in = best_idx_ff;
      if (pend_ff && take) begin
         best_val_in = $signed(rd_data);
         best_idx_in = pend_idx_ff;
      end
   end

   // update arithmetic
   assign tgt_sum   = {{3{op_reward_ff[VALUE_W-1]}}, op_reward_ff}
                    + {prod1_ff[49], prod1_ff[49:16]};
   assign diff      = {target_ff[VALUE_W-1], target_ff} - {q_ff[VALUE_W-1], q_ff};
   assign upd_sum   = {{4{q_ff[VALUE_W-1]}}, q_ff} + {prod2_ff[50], prod2_ff[50:16]};
   assign new_value = sat_value({{(SAT_W-36){upd_sum[35]}}, upd_sum});

   // sequencer
   always_comb begin
      fsm_in        = fsm_ff;
      clear_addr_in = clear_addr_ff;
      scan_idx_in   = scan_idx_ff;
      pend_in       = 1'b0;
      mod_cnt_in    = mod_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      op_update_in  = op_update_ff;
      op_boot_in    = op_boot_ff;
      rsp_load      = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = clear_addr_ff;
      mem_wdata     = '0;
      mem_raddr     = entry_addr(op_state_ff, {1'b0, op_action_ff});

      unique case (fsm_ff)
         ST_CLEAR: begin
            mem_we        = 1'b1;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == LAST_ADDR) begin
               fsm_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               fsm_in       = accept_next;
               scan_idx_in  = '0;
               mod_cnt_in   = '0;
               op_update_in = (req_func == FUNC_UPDATE);
               op_boot_in   = !req_episode_done && ns_ok;
            end
         end
         ST_MOD: begin
            mod_cnt_in = mod_cnt_ff + 1'b1;
            if (mod_cnt_ff == MOD_LAST) begin
               fsm_in = ST_RESULT;
            end
         end
         ST_QREAD: fsm_in = ST_QDATA;
         ST_QDATA: begin
            if (!op_update_ff) begin
               fsm_in = ST_RESULT;
            end else if (op_boot_ff) begin
               fsm_in = ST_SCAN;
            end else begin
               fsm_in = ST_MUL1;
            end
         end
         ST_SCAN: begin
            mem_raddr   = entry_addr(scan_row_ff, scan_idx_ff);
            pend_in     = 1'b1;
            scan_idx_in = scan_idx_ff + 1'b1;
            if (scan_idx_ff == n_actions - 1'b1) begin
               fsm_in = ST_SLAST;
            end
         end
         ST_SLAST: fsm_in = op_update_ff ? ST_MUL1 : ST_RESULT;
         ST_MUL1:  fsm_in = ST_TGT;
         ST_TGT:   fsm_in = ST_MUL2;
         ST_MUL2:  fsm_in = ST_WRITE;
         ST_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = entry_addr(op_state_ff, {1'b0, op_action_ff});
            mem_wdata = new_value;
            fsm_in    = ST_IDLE;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               fsm_in       = ST_IDLE;
            end
         end
         default: fsm_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      op_state_in   = op_state_ff;
      op_action_in  = op_action_ff;
      op_reward_in  = op_reward_ff;
      scan_row_in   = scan_row_ff;
      mod_pick_in   = mod_pick_ff;
      mod_rem_in    = mod_rem_ff;
      pend_idx_in   = scan_idx_ff;
      q_in          = q_ff;
      max_in        = max_ff;
      prod1_in      = prod1_ff;
      target_in     = target_ff;
      prod2_in      = prod2_ff;
      res_action_in = res_action_ff;
      res_value_in  = res_value_ff;
      rsp_action_in = rsp_action_ff;
      rsp_value_in  = rsp_value_ff;

      if (req_accept) begin
         op_state_in   = req_state_index;
         op_action_in  = req_action_index;
         op_reward_in  = req_reward;
         scan_row_in   = (req_func == FUNC_SELECT) ? req_state_index : req_next_state_index;
         mod_pick_in   = req_explore_pick;
         mod_rem_in    = '0;
         max_in        = '0;
         res_action_in = '0;
         res_value_in  = '0;
      end
      if (fsm_ff == ST_MOD) begin
         mod_rem_in    = mod_rem_step;
         mod_pick_in   = mod_pick_ff << MOD_BITS;
         res_action_in = mod_rem_step[ACTION_W-1:0];
      end
      if (fsm_ff == ST_QDATA) begin
         q_in = $signed(rd_data);
         if (!op_update_ff) begin
            res_value_in = rd_data;
         end
      end
      if (fsm_ff == ST_SLAST) begin
         max_in        = best_val_in;
         res_action_in = best_idx_in[ACTION_W-1:0];
      end
      if (fsm_ff == ST_MUL1) begin
         prod1_in = $signed({1'b0, csr_gamma_ff}) * max_ff;
      end
      if (fsm_ff == ST_TGT) begin
         target_in = $signed(sat_value({{(SAT_W-35){tgt_sum[34]}}, tgt_sum}));
      end
      if (fsm_ff == ST_MUL2) begin
         prod2_in = $signed({1'b0, csr_alpha_ff}) * diff;
      end
      if (rsp_load) begin
         rsp_action_in = res_action_ff;
         rsp_value_in  = res_value_ff;
      end
   end

   // configuration registers
   always_comb begin
      csr_states_in  = csr_states_ff;
      csr_actions_in = csr_actions_ff;
      csr_alpha_in   = csr_alpha_ff;
      csr_gamma_in   = csr_gamma_ff;
      csr_eps_in     = csr_eps_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STATES:  csr_states_in  = csr_wr_data[STATES_W-1:0];
            CSR_ACTIONS: csr_actions_in = csr_wr_data[COUNT_W-1:0];
            CSR_ALPHA:   csr_alpha_in   = csr_wr_data[GAIN_W-1:0];
            CSR_GAMMA:   csr_gamma_in   = csr_wr_data[GAIN_W-1:0];
            CSR_EPS:     csr_eps_in     = csr_wr_data[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff         <= ST_CLEAR;
         clear_addr_ff  <= '0;
         scan_idx_ff    <= '0;
         pend_ff        <= 1'b0;
         mod_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         op_update_ff   <= 1'b0;
         op_boot_ff     <= 1'b0;
         csr_states_ff  <= RST_STATES;
         csr_actions_ff <= RST_ACTIONS;
         csr_alpha_ff   <= RST_ALPHA;
         csr_gamma_ff   <= RST_GAMMA;
         csr_eps_ff     <= RST_EPS;
      end else begin
         fsm_ff         <= fsm_in;
         clear_addr_ff  <= clear_addr_in;
         scan_idx_ff    <= scan_idx_in;
         pend_ff        <= pend_in;
         mod_cnt_ff     <= mod_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         op_update_ff   <= op_update_in;
         op_boot_ff     <= op_boot_in;
         csr_states_ff  <= csr_states_in;
         csr_actions_ff <= csr_actions_in;
         csr_alpha_ff   <= csr_alpha_in;
         csr_gamma_ff   <= csr_gamma_in;
         csr_eps_ff     <= csr_eps_in;
      end
   end

   always_ff @(posedge clock) begin
      op_state_ff   <= op_state_in;
      op_action_ff  <= op_action_in;
      op_reward_ff  <= op_reward_in;
      scan_row_ff   <= scan_row_in;
      mod_pick_ff   <= mod_pick_in;
      mod_rem_ff    <= mod_rem_in;
      pend_idx_ff   <= pend_idx_in;
      best_val_ff   <= best_val_in;
      best_idx_ff   <= best_idx_in;
      q_ff          <= q_in;
      max_ff        <= max_in;
      prod1_ff      <= prod1_in;
      target_ff     <= target_in;
      prod2_ff      <= prod2_in;
      res_action_ff <= res_action_in;
      res_value_ff  <= res_value_in;
      rsp_action_ff <= rsp_action_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_action = rsp_action_ff;
   assign rsp_entry_value   = $signed(rsp_value_ff);

   `TQLE_ASSERT_SAME(a_rsp_no_overwrite, clock, reset, rsp_load, !rsp_valid_ff || !rsp_stall, "pending word overwritten")
   `TQLE_ASSERT_SAME(a_scan_in_row, clock, reset, fsm_ff == ST_SCAN, scan_idx_ff < n_actions, "row scan past action count")
   `TQLE_ASSERT_NEXT(a_write_ends_op, clock, reset, fsm_ff == ST_WRITE, fsm_ff == ST_IDLE, "write-back not followed by idle")

endmodule

`default_nettype wire

// ===== test/tb_tabular_q_learning_engine.sv =====
// ----------------------------------------------------------------------------
// tb_tabular_q_learning_engine
// Self-checking bench for the Q-table engine: a queue-fed request driver, a
// response monitor with random stalls, and an in-bench predictor of the
// table, the gains and the epsilon-greedy choice, checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tabular_q_learning_engine
   import tqle_pkg::*;
();

   localparam int MAX_STATES      = 256;
   localparam int MAX_ACTIONS     = 8;
   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 5;
   localparam int DRAIN_CYCLES    = 40;
   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 165;
   // clear pass plus ~1400 words at worst-case op, gap and stall, many times over
   localparam int LIMIT_CYCLES    = 1000000;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [FUNC_W-1:0]          func;
      logic [STATE_W-1:0]         state;
      logic [ACTION_W-1:0]        act;
      logic signed [VALUE_W-1:0]  reward;
      logic [STATE_W-1:0]         succ_state;
      logic                       done;
      logic [DRAW_W-1:0]          draw;
      logic [DRAW_W-1:0]          pick;
   } req_type;

   typedef struct {
      logic [ACTION_W-1:0]        action;
      logic signed [VALUE_W-1:0]  value;
   } answer_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [FUNC_W-1:0]           req_func = '0;
   logic [STATE_W-1:0]          req_state_index = '0;
   logic [ACTION_W-1:0]         req_action_index = '0;
   logic signed [VALUE_W-1:0]   req_reward = '0;
   logic [STATE_W-1:0]          req_next_state_index = '0;
   logic                        req_episode_done = 1'b0;
   logic [DRAW_W-1:0]           req_explore_draw = '0;
   logic [DRAW_W-1:0]           req_explore_pick = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [ACTION_W-1:0]         rsp_chosen_action;
   logic signed [VALUE_W-1:0]   rsp_entry_value;
   logic                        csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_wr_data = '0;

   // mirror of the engine
   logic signed [VALUE_W-1:0]   q_mirror [0:MAX_STATES*MAX_ACTIONS-1];
   logic [STATES_W-1:0]         cfg_states  = RST_STATES;
   logic [COUNT_W-1:0]          cfg_actions = RST_ACTIONS;
   logic [GAIN_W-1:0]           cfg_alpha   = RST_ALPHA;
   logic [GAIN_W-1:0]           cfg_gamma   = RST_GAMMA;
   logic [GAIN_W-1:0]           cfg_eps     = RST_EPS;

   req_type     request_q [$];
   answer_type  answer_q [$];
   req_type     word_on_bus;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned req_gap = 0;
   int unsigned req_calm = 0;
   int unsigned rsp_hold = 0;
   int unsigned rsp_calm = 0;

   tabular_q_learning_engine #(
      .MAX_STATES  (MAX_STATES),
      .MAX_ACTIONS (MAX_ACTIONS)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_state_index      (req_state_index),
      .req_action_index     (req_action_index),
      .req_reward           (req_reward),
      .req_next_state_index (req_next_state_index),
      .req_episode_done     (req_episode_done),
      .req_explore_draw     (req_explore_draw),
      .req_explore_pick     (req_explore_pick),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_chosen_action    (rsp_chosen_action),
      .rsp_entry_value      (rsp_entry_value),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic int unsigned live_states();
      return (cfg_states < MAX_STATES) ? cfg_states : MAX_STATES;
   endfunction

   function automatic int unsigned live_actions();
      if (cfg_actions == 0) begin
         return 1;
      end
      return (cfg_actions < MAX_ACTIONS) ? cfg_actions : MAX_ACTIONS;
   endfunction

   function automatic longint q_at(input int unsigned s, input int unsigned a);
      if (s >= live_states() || a >= live_actions()) begin
         return 0;
      end
      return q_mirror[s*MAX_ACTIONS + a];
   endfunction

   function automatic longint sat32(input longint x);
      if (x > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return x;
   endfunction

   // one accepted request word -> table write and/or expected response word
   function automatic void apply_request(input req_type r);
      answer_type  ans;
      int unsigned n_act;
      int unsigned best_a;
      int unsigned i;
      longint      best;
      longint      v;
      longint      qsa;
      longint      target;
      longint      delta;
      n_act = live_actions();
      ans.action = '0;
      ans.value = '0;
      case (r.func)
         FUNC_SELECT: begin
            best_a = 0;
            if (r.draw < cfg_eps) begin
               best_a = r.pick % n_act;
            end else begin
               best = q_at(r.state, 0);
               for (i = 1; i < n_act; i++) begin
                  v = q_at(r.state, i);
                  if (v > best) begin
                     best = v;
                     best_a = i;
                  end
               end
            end
            ans.action = best_a[ACTION_W-1:0];
            answer_q.push_back(ans);
         end
         FUNC_UPDATE: begin
            if (r.state < live_states() && r.act < n_act) begin
               qsa = q_at(r.state, r.act);
               best = 0;
               if (!r.done) begin
                  best = q_at(r.succ_state, 0);
                  for (i = 1; i < n_act; i++) begin
                     v = q_at(r.succ_state, i);
                     if (v > best) begin
                        best = v;
                     end
                  end
               end
               target = sat32(longint'(r.reward) + ((longint'(cfg_gamma) * best) >>> 16));
               delta = (longint'(cfg_alpha) * (target - qsa)) >>> 16;
               q_mirror[r.state*MAX_ACTIONS + r.act] = VALUE_W'(sat32(qsa + delta));
            end
         end
         FUNC_READ: begin
            ans.value = VALUE_W'(q_at(r.state, r.act));
            answer_q.push_back(ans);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic int unsigned idle_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin : req_driver
      req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_request(word_on_bus);
         end
         if (!req_valid || !req_stall) begin
            if (req_calm != 0) begin
               req_calm--;
            end
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (request_q.size() != 0) begin
               nxt = request_q.pop_front();
               word_on_bus = nxt;
               req_func             <= nxt.func;
               req_state_index      <= nxt.state;
               req_action_index     <= nxt.act;
               req_reward           <= nxt.reward;
               req_next_state_index <= nxt.succ_state;
               req_episode_done     <= nxt.done;
               req_explore_draw     <= nxt.draw;
               req_explore_pick     <= nxt.pick;
               req_valid            <= 1'b1;
               if (req_calm == 0 && $urandom_range(0, 49) == 0) begin
                  req_calm = $urandom_range(30, 120);
               end
               req_gap = (req_calm != 0) ? 0 : idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      answer_type want;
      int unsigned n;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answer_q.size() == 0) begin
            $error("response word with no expected answer");
            mismatch_count++;
         end else begin
            want = answer_q.pop_front();
            if (rsp_chosen_action !== want.action) begin
               $error("chosen_action: expected %0d, actual %0d", want.action,
                      rsp_chosen_action);
               mismatch_count++;
            end
            if (rsp_entry_value !== want.value) begin
               $error("entry_value: expected %0d, actual %0d", want.value,
                      rsp_entry_value);
               mismatch_count++;
            end
         end
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_calm != 0) begin
         rsp_calm--;
         rsp_stall <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else begin
         n = idle_length();
         if ($urandom_range(0, 49) == 0) begin
            rsp_calm = $urandom_range(30, 120);
         end
         rsp_stall <= (n != 0);
         rsp_hold = (n != 0) ? n - 1 : 0;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val[CSR_DATA_W-1:0];
      case (idx)
         CSR_STATES:  cfg_states  = val[STATES_W-1:0];
         CSR_ACTIONS: cfg_actions = val[COUNT_W-1:0];
         CSR_ALPHA:   cfg_alpha   = val[GAIN_W-1:0];
         CSR_GAMMA:   cfg_gamma   = val[GAIN_W-1:0];
         CSR_EPS:     cfg_eps     = val[GAIN_W-1:0];
         default: begin
         end
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_config(input int unsigned st, input int unsigned ac,
                               input int unsigned al, input int unsigned ga,
                               input int unsigned ep);
      write_reg(CSR_STATES, st);
      write_reg(CSR_ACTIONS, ac);
      write_reg(CSR_ALPHA, al);
      write_reg(CSR_GAMMA, ga);
      write_reg(CSR_EPS, ep);
   endtask

   // all words out, all answers in, then room for a trailing update
   task automatic wait_drained();
      @(negedge clock);
      while (request_q.size() != 0 || req_valid || answer_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void queue_word(input logic [FUNC_W-1:0] f, input int unsigned s,
                                      input int unsigned a, input logic [31:0] rw,
                                      input int unsigned ns, input int unsigned dn,
                                      input int unsigned dr, input int unsigned pk);
      req_type r;
      r.func = f;
      r.state = s[STATE_W-1:0];
      r.act = a[ACTION_W-1:0];
      r.reward = rw;
      r.succ_state = ns[STATE_W-1:0];
      r.done = dn[0];
      r.draw = dr[DRAW_W-1:0];
      r.pick = pk[DRAW_W-1:0];
      request_q.push_back(r);
   endfunction

   function automatic logic [31:0] any_reward();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      end
      if (roll < 75) begin
         return $urandom();
      end
      if (roll < 85) begin
         return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      return '0;
   endfunction

   function automatic int unsigned any_draw();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return $urandom_range(0, 65535);
      end
      if (roll < 85) begin
         return (cfg_eps > 65535) ? 65535 : cfg_eps - $urandom_range(0, 1);
      end
      return ($urandom_range(0, 1) != 0) ? 65535 : 0;
   endfunction

   function automatic int unsigned any_state();
      if (live_states() == 0 || $urandom_range(0, 19) == 0) begin
         return $urandom_range(0, 255);
      end
      return $urandom_range(0, live_states() - 1);
   endfunction

   // one agent step: choose, learn, sometimes look back at the entry
   function automatic int unsigned agent_step(inout int unsigned s);
      int unsigned a;
      int unsigned ns;
      int unsigned words;
      bit          dn;
      a = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 7)
                                       : $urandom_range(0, live_actions() - 1);
      ns = any_state();
      dn = ($urandom_range(0, 7) == 0);
      queue_word(FUNC_SELECT, s, 0, $urandom(), $urandom_range(0, 255), $urandom_range(0, 1),
                 any_draw(), $urandom_range(0, 65535));
      queue_word(FUNC_UPDATE, s, a, any_reward(), ns, dn, $urandom_range(0, 65535),
                 $urandom_range(0, 65535));
      words = 2;
      if ($urandom_range(0, 3) == 0) begin
         queue_word(FUNC_READ, s, a, $urandom(), $urandom_range(0, 255), $urandom_range(0, 1),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
         words++;
      end
      s = dn ? any_state() : ns;
      return words;
   endfunction

   function automatic int unsigned rand_states();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return $urandom_range(1, 8);
      if (roll < 65) return $urandom_range(9, 256);
      if (roll < 75) return 256;
      if (roll < 85) return 1;
      if (roll < 90) return 0;
      return $urandom_range(257, 511);
   endfunction

   function automatic int unsigned rand_actions();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 8);
      if (roll < 90) return 0;
      return $urandom_range(9, 15);
   endfunction

   function automatic int unsigned rand_gain();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 0;
      if (roll < 25) return 65536;
      return $urandom_range(1, 65535);
   endfunction

   function automatic int unsigned rand_eps();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 0;
      if (roll < 20) return 65536;
      if (roll < 25) return $urandom_range(65537, 131071);
      return $urandom_range(0, 65535);
   endfunction

   initial begin : stimulus
      int unsigned ph;
      int unsigned words;
      int unsigned walker;
      foreach (q_mirror[i]) begin
         q_mirror[i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: greedy/explore, extreme rewards, bootstrap, unused code
      queue_word(FUNC_SELECT, 0, 0, 0, 0, 0, 65535, 0);
      queue_word(FUNC_SELECT, 0, 0, 0, 0, 0, 0, 65535);
      queue_word(FUNC_UPDATE, 3, 2, 32'h7FFF_FFFF, 0, 1, 0, 0);
      queue_word(FUNC_UPDATE, 3, 5, 32'h8000_0000, 3, 0, 0, 0);
      queue_word(FUNC_READ, 3, 2, 0, 0, 0, 0, 0);
      queue_word(FUNC_READ, 3, 5, 0, 0, 0, 0, 0);
      queue_word(FUNC_SELECT, 3, 0, 0, 0, 0, 65535, 0);
      queue_word(FUNC_UPDATE, 255, 7, 32'h0001_0000, 3, 0, 0, 0);
      queue_word(FUNC_READ, 255, 7, 0, 0, 0, 0, 0);
      queue_word(FUNC_UNUSED, 0, 0, 32'hFFFF_FFFF, 255, 1, 65535, 65535);
      wait_drained();

      // small table, full gains, never explore: range checks and saturation
      write_config(4, 3, 65536, 65536, 0);
      queue_word(FUNC_SELECT, 200, 0, 0, 0, 0, 0, 0);
      queue_word(FUNC_UPDATE, 5, 0, 32'h0001_0000, 0, 1, 0, 0);
      queue_word(FUNC_UPDATE, 3, 5, 32'h0001_0000, 0, 1, 0, 0);
      queue_word(FUNC_UPDATE, 3, 1, 32'h7FFF_FFFF, 200, 0, 0, 0);
      queue_word(FUNC_UPDATE, 2, 0, 32'h7FFF_FFFF, 3, 0, 0, 0);
      queue_word(FUNC_READ, 2, 0, 0, 0, 0, 0, 0);
      queue_word(FUNC_READ, 200, 0, 0, 0, 0, 0, 0);
      queue_word(FUNC_READ, 3, 7, 0, 0, 0, 0, 0);
      queue_word(FUNC_SELECT, 3, 0, 0, 0, 0, 65535, 0);
      wait_drained();

      // zero states and actions, zero gains, always explore
      write_config(0, 0, 0, 0, 65536);
      queue_word(FUNC_SELECT, 0, 0, 0, 0, 0, 65535, 12345);
      queue_word(FUNC_UPDATE, 0, 0, 32'h0001_0000, 0, 1, 0, 0);
      queue_word(FUNC_READ, 0, 0, 0, 0, 0, 0, 0);
      wait_drained();

      // oversized counts and threshold
      write_config(511, 15, 32768, 0, 70000);
      queue_word(FUNC_SELECT, 3, 0, 0, 0, 0, 65535, 65534);
      queue_word(FUNC_UPDATE, 3, 2, 32'hFFFF_0000, 255, 0, 0, 0);
      queue_word(FUNC_READ, 3, 2, 0, 0, 0, 0, 0);
      wait_drained();

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_config(rand_states(), rand_actions(), rand_gain(), rand_gain(), rand_eps());
         walker = any_state();
         words = 0;
         while (words < WORDS_PER_PHASE) begin
            if ($urandom_range(0, 9) < 8) begin
               words += agent_step(walker);
            end else begin
               queue_word(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 255),
                          $urandom_range(0, 7), $urandom(), $urandom_range(0, 255),
                          $urandom_range(0, 1), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
               words++;
            end
         end
         wait_drained();
      end

      if (mismatch_count == 0 && answer_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== tabular_q_learning_engine.f =====
+incdir+rtl
rtl/tqle_pkg.sv
rtl/tqle_ram.sv
rtl/tabular_q_learning_engine.sv
test/tb_tabular_q_learning_engine.sv
